// ===== src/weighted_graph_adjacency_store_macros.svh =====
// Assertion shorthands shared by the graph store modules.
// Each macro is clocked on clk and is quiet while arst_n is low.
`ifndef WEIGHTED_GRAPH_ADJACENCY_STORE_MACROS_SVH
`define WEIGHTED_GRAPH_ADJACENCY_STORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WGAS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WGAS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/wgas_pkg.sv =====
`timescale 1ns / 1ps
package wgas_pkg;

	// Default sizes of the node table and of each edge list.
	localparam int NODES_DEF = 16;
	localparam int EDGES_DEF = 16;

	// Name returned for a position outside the table, and the count ceiling.
	localparam logic [7:0] DASH_NAME = 8'd45;
	localparam logic [8:0] COUNT_CAP = 9'd511;

	typedef enum logic [3:0] {
		OP_ADD_NODE   = 4'd0,
		OP_REM_NODE   = 4'd1,
		OP_ADD_EDGE   = 4'd2,
		OP_REM_EDGE   = 4'd3,
		OP_FIND_NODE  = 4'd4,
		OP_FIND_EDGE  = 4'd5,
		OP_CNT_NODES  = 4'd6,
		OP_CNT_EDGES  = 4'd7,
		OP_CNT_LOOPS  = 4'd8,
		OP_NAME_POS   = 4'd9,
		OP_POS_NAME   = 4'd10,
		OP_MATRIX     = 4'd11
	} opcode_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_NOCHANGE = 2'd1,
		ST_FULL     = 2'd2,
		ST_RANGE    = 2'd3
	} status_t;

	// Which position selects the order table entry.
	typedef enum logic [1:0] {
		PS_I,
		PS_ROW,
		PS_COL
	} psel_t;

	typedef enum logic [1:0] {
		RS_HOLD,
		RS_NODE,
		RS_PERM
	} rs_sel_t;

	typedef enum logic [1:0] {
		KEY_HOLD,
		KEY_TARGET,
		KEY_NAME,
		KEY_PNAME
	} key_sel_t;

	// Edge memory read address source.
	typedef enum logic [2:0] {
		MR_NONE,
		MR_LOC,
		MR_UP,
		MR_DN,
		MR_E
	} mrd_t;

	typedef enum logic [1:0] {
		MW_NONE,
		MW_COPY,
		MW_NEW
	} mwr_t;

	typedef enum logic [2:0] {
		K_NONE,
		K_LOAD_E,
		K_LOAD_DEG,
		K_INC,
		K_DEC
	} kop_t;

	typedef enum logic [1:0] {
		D_NONE,
		D_INC,
		D_DEC
	} dop_t;

	typedef enum logic [1:0] {
		CN_NONE,
		CN_TOTAL,
		CN_DEG,
		CN_HIT
	} cop_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     capture;
		logic     scan_step;
		psel_t    psel;
		logic     i_clr;
		logic     i_inc;
		rs_sel_t  rs_sel;
		key_sel_t key_sel;
		logic     loc_init;
		logic     loc_cmp;
		mrd_t     mrd;
		mwr_t     mwr;
		kop_t     kop;
		dop_t     dop;
		cop_t     cop;
		logic     node_add;
		logic     node_del;
		logic     w_cap;
		logic     st_en;
		status_t  st;
		logic     fin;
	} cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		opcode_t op;
		logic    hit;
		logic    ehit;
		logic    i_end;
		logic    j_end;
		logic    full;
		logic    row_full;
		logic    drop_end;
		logic    ins_end;
		logic    row_ok;
		logic    rc_ok;
		logic    out_free;
	} sts_t;

endpackage

// ===== src/wgas_dp.sv =====
`timescale 1ns / 1ps
module wgas_dp import wgas_pkg::*; #(
	parameter int NODES = NODES_DEF,
	parameter int EDGES = EDGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic [3:0]         operation,
	input  logic [7:0]         node_name,
	input  logic [7:0]         target_name,
	input  logic signed [31:0] edge_weight,
	input  logic [3:0]         row_position,
	input  logic [3:0]         column_position,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic               found,
	output logic [8:0]         count,
	output logic [3:0]         position,
	output logic [7:0]         result_name,
	output logic signed [31:0] result_weight,
	output logic               weight_valid
);
`include "weighted_graph_adjacency_store_macros.svh"

	localparam int NW = $clog2(NODES);
	localparam int TW = $clog2(NODES + 1);
	localparam int EW = (EDGES > 1) ? $clog2(EDGES) : 1;
	localparam int DW = $clog2(EDGES + 1);
	localparam int AW = NW + EW;
	localparam int MD = NODES << EW;
	localparam int RW = (TW > 4) ? TW : 4;

	// Captured input word.
	opcode_t            op_q;
	logic [7:0]         name_in_q;
	logic [7:0]         tgt_in_q;
	logic signed [31:0] wt_in_q;
	logic [3:0]         row_q;
	logic [3:0]         col_q;

	// Node table held by slot, plus the sorted order of slots.
	logic [7:0]    names_q [NODES];
	logic [NODES-1:0] used_q;
	logic [DW-1:0] deg_q [NODES];
	logic [NW-1:0] perm_q [NODES];
	logic [TW-1:0] total_q;

	// Scan and edge walk registers.
	logic [TW-1:0] i_q;
	logic [TW-1:0] ins_q;
	logic          hit_q;
	logic [NW-1:0] npos_q;
	logic [NW-1:0] nslot_q;
	logic [NW-1:0] rs_q;
	logic [7:0]    key_q;
	logic [DW-1:0] j_q;
	logic [DW-1:0] lt_q;
	logic [DW-1:0] e_q;
	logic          ehit_q;
	logic [DW-1:0] k_q;
	logic [8:0]    cnt_q;
	status_t       st_q;
	logic [31:0]   wt_q;
	logic          wv_q;

	// Edge memory: target name over weight.
	logic [39:0]   emem [MD];
	logic [39:0]   rd_q;

	// Output register.
	logic               out_valid_q;
	logic [1:0]         status_q;
	logic               found_q;
	logic [8:0]         count_q;
	logic [3:0]         position_q;
	logic [7:0]         result_name_q;
	logic signed [31:0] result_weight_q;
	logic               weight_valid_q;

	logic [NW-1:0] perm_idx;
	logic [NW-1:0] perm_rd;
	logic [7:0]    name_rd;
	logic [DW-1:0] deg_rs;
	logic [NW-1:0] free_slot;
	logic          row_ok;
	logic          col_ok;
	logic [DW-1:0] rd_idx;
	logic          ren;
	logic [AW-1:0] raddr;
	logic          wen;
	logic [AW-1:0] waddr;
	logic [39:0]   wdata;
	logic [9:0]    cnt_sum;

	// Single read port into the order table and the name table.
	always_comb begin
		case (cmd.psel)
			PS_ROW:  perm_idx = NW'(row_q);
			PS_COL:  perm_idx = NW'(col_q);
			default: perm_idx = NW'(i_q);
		endcase
	end
	assign perm_rd = perm_q[perm_idx];
	assign name_rd = names_q[perm_rd];
	assign deg_rs  = deg_q[rs_q];

	// Lowest free slot for a new node.
	always_comb begin
		free_slot = '0;
		for (int s = NODES - 1; s >= 0; s--) begin
			if (!used_q[s]) begin
				free_slot = NW'(s);
			end
		end
	end

	assign row_ok = RW'(row_q) < RW'(total_q);
	assign col_ok = RW'(col_q) < RW'(total_q);

	// Edge memory address selection.
	always_comb begin
		ren = 1'b1;
		case (cmd.mrd)
			MR_LOC:  rd_idx = j_q;
			MR_UP:   rd_idx = k_q + DW'(1);
			MR_DN:   rd_idx = k_q - DW'(1);
			MR_E:    rd_idx = e_q;
			default: begin
				rd_idx = j_q;
				ren = 1'b0;
			end
		endcase
	end
	assign raddr = {rs_q, EW'(rd_idx)};
	assign wen   = (cmd.mwr != MW_NONE);
	assign waddr = {rs_q, EW'((cmd.mwr == MW_NEW) ? lt_q : k_q)};
	assign wdata = (cmd.mwr == MW_NEW) ? {tgt_in_q, wt_in_q} : rd_q;

	always_ff @(posedge clk) begin
		if (wen) begin
			emem[waddr] <= wdata;
		end
		if (ren) begin
			rd_q <= emem[raddr];
		end
	end

	// Saturating edge sum.
	assign cnt_sum = {1'b0, cnt_q} + 10'(deg_rs);

	// Captured word, node names and the order table; no reset needed.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= opcode_t'(operation);
			name_in_q <= node_name;
			tgt_in_q  <= target_name;
			wt_in_q   <= edge_weight;
			row_q     <= row_position;
			col_q     <= column_position;
		end
		if (cmd.node_add) begin
			names_q[free_slot] <= name_in_q;
			if (ins_q == '0) begin
				perm_q[0] <= free_slot;
			end
			for (int p = 1; p < NODES; p++) begin
				if (TW'(p) == ins_q) begin
					perm_q[p] <= free_slot;
				end else if (TW'(p) > ins_q) begin
					perm_q[p] <= perm_q[p-1];
				end
			end
		end
		if (cmd.node_del) begin
			for (int p = 0; p < NODES - 1; p++) begin
				if (NW'(p) >= npos_q) begin
					perm_q[p] <= perm_q[p+1];
				end
			end
		end
		if (cmd.w_cap) begin
			wt_q <= rd_q[31:0];
		end
	end

	// Control state of the table and of the walks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			total_q <= '0;
			for (int s = 0; s < NODES; s++) begin
				deg_q[s] <= '0;
			end
			i_q     <= '0;
			ins_q   <= '0;
			hit_q   <= 1'b0;
			npos_q  <= '0;
			nslot_q <= '0;
			rs_q    <= '0;
			key_q   <= '0;
			j_q     <= '0;
			lt_q    <= '0;
			e_q     <= '0;
			ehit_q  <= 1'b0;
			k_q     <= '0;
			cnt_q   <= '0;
			st_q    <= ST_NOCHANGE;
			wv_q    <= 1'b0;
		end else begin
			// A new word clears the scan and result state.
			if (cmd.capture) begin
				i_q   <= '0;
				ins_q <= '0;
				hit_q <= 1'b0;
				cnt_q <= '0;
				wv_q  <= 1'b0;
				st_q  <= ST_NOCHANGE;
			end
			// One sorted position per cycle during the name search.
			if (cmd.scan_step) begin
				if (name_rd == name_in_q) begin
					hit_q   <= 1'b1;
					npos_q  <= NW'(i_q);
					nslot_q <= perm_rd;
				end
				if (name_rd < name_in_q) begin
					ins_q <= ins_q + TW'(1);
				end
				i_q <= i_q + TW'(1);
			end
			if (cmd.i_clr) begin
				i_q <= '0;
			end
			if (cmd.i_inc) begin
				i_q <= i_q + TW'(1);
			end
			case (cmd.rs_sel)
				RS_NODE: rs_q <= nslot_q;
				RS_PERM: rs_q <= perm_rd;
				default: rs_q <= rs_q;
			endcase
			case (cmd.key_sel)
				KEY_TARGET: key_q <= tgt_in_q;
				KEY_NAME:   key_q <= name_in_q;
				KEY_PNAME:  key_q <= name_rd;
				default:    key_q <= key_q;
			endcase
			// Edge list walk: one entry per compare.
			if (cmd.loc_init) begin
				j_q    <= '0;
				lt_q   <= '0;
				e_q    <= '0;
				ehit_q <= 1'b0;
			end
			if (cmd.loc_cmp) begin
				if (rd_q[39:32] == key_q) begin
					ehit_q <= 1'b1;
					e_q    <= j_q;
				end
				if (rd_q[39:32] < key_q) begin
					lt_q <= lt_q + DW'(1);
				end
				j_q <= j_q + DW'(1);
			end
			case (cmd.kop)
				K_LOAD_E:   k_q <= e_q;
				K_LOAD_DEG: k_q <= deg_rs;
				K_INC:      k_q <= k_q + DW'(1);
				K_DEC:      k_q <= k_q - DW'(1);
				default:    k_q <= k_q;
			endcase
			case (cmd.dop)
				D_INC:   deg_q[rs_q] <= deg_rs + DW'(1);
				D_DEC:   deg_q[rs_q] <= deg_rs - DW'(1);
				default: ;
			endcase
			case (cmd.cop)
				CN_TOTAL: cnt_q <= 9'(total_q);
				CN_DEG:   cnt_q <= (cnt_sum > 10'(COUNT_CAP)) ? COUNT_CAP : cnt_sum[8:0];
				CN_HIT: begin
					if (ehit_q && cnt_q != COUNT_CAP) begin
						cnt_q <= cnt_q + 9'd1;
					end
				end
				default: ;
			endcase
			// Node insertion and removal.
			if (cmd.node_add) begin
				used_q[free_slot] <= 1'b1;
				deg_q[free_slot]  <= '0;
				total_q           <= total_q + TW'(1);
			end
			if (cmd.node_del) begin
				used_q[nslot_q] <= 1'b0;
				total_q         <= total_q - TW'(1);
			end
			if (cmd.w_cap) begin
				wv_q <= 1'b1;
			end
			if (cmd.st_en) begin
				st_q <= cmd.st;
			end
		end
	end

	// Result word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			status_q <= st_q;
			found_q  <= ((op_q == OP_FIND_NODE) || (op_q == OP_NAME_POS) ||
				(op_q == OP_FIND_EDGE)) && (st_q == ST_DONE);
			count_q  <= ((op_q == OP_CNT_NODES) || (op_q == OP_CNT_EDGES) ||
				(op_q == OP_CNT_LOOPS)) ? cnt_q : 9'd0;
			position_q <= (((op_q == OP_FIND_NODE) || (op_q == OP_NAME_POS)) && hit_q) ?
				4'(npos_q) : 4'd0;
			if (op_q == OP_POS_NAME) begin
				result_name_q <= row_ok ? name_rd : DASH_NAME;
			end else begin
				result_name_q <= 8'd0;
			end
			result_weight_q <= ((op_q == OP_MATRIX) && wv_q) ? wt_q : 32'sd0;
			weight_valid_q  <= (op_q == OP_MATRIX) && wv_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign found         = found_q;
	assign count         = count_q;
	assign position      = position_q;
	assign result_name   = result_name_q;
	assign result_weight = result_weight_q;
	assign weight_valid  = weight_valid_q;

	// Status back to the controller.
	always_comb begin
		sts.op       = op_q;
		sts.hit      = hit_q;
		sts.ehit     = ehit_q;
		sts.i_end    = (i_q == total_q);
		sts.j_end    = (j_q == deg_rs);
		sts.full     = (total_q == TW'(NODES));
		sts.row_full = ((DW + 1)'(deg_rs) >= (DW + 1)'(EDGES));
		sts.drop_end = ((DW + 1)'(k_q) + (DW + 1)'(1) >= (DW + 1)'(deg_rs));
		sts.ins_end  = (k_q == lt_q);
		sts.row_ok   = row_ok;
		sts.rc_ok    = row_ok && col_ok;
		sts.out_free = !out_valid_q || !out_stall;
	end

	// The node count never passes the table size and matches the slots in use.
	`WGAS_ASSERT_NOW(a_total_range, 1'b1, total_q <= TW'(NODES), "node count above table size")
	`WGAS_ASSERT_NOW(a_used_total, 1'b1, $countones(used_q) == 32'(total_q),
		"slot map disagrees with node count")
	// A finished operation shows its word in the next cycle.
	`WGAS_ASSERT_NEXT(a_fin_valid, cmd.fin, out_valid_q, "result word not presented")
	// A node is added only when a slot is free.
	`WGAS_ASSERT_NOW(a_add_room, cmd.node_add, !used_q[free_slot], "node added without room")

endmodule

// ===== src/wgas_ctrl.sv =====
`timescale 1ns / 1ps
module wgas_ctrl import wgas_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_NSCAN,
		S_DISPATCH,
		S_RROW,
		S_EROW,
		S_EADD,
		S_MROW,
		S_LRD,
		S_LCMP,
		S_LDONE,
		S_DRD,
		S_DWR,
		S_IRD,
		S_IWR,
		S_WCAP,
		S_FIN
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;

	assign in_stall = busy_q;

	// State register and the registered stall.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
		end
	end

	// Commands and next state for each step.
	always_comb begin
		cmd         = '0;
		cmd.psel    = PS_I;
		cmd.rs_sel  = RS_HOLD;
		cmd.key_sel = KEY_HOLD;
		cmd.mrd     = MR_NONE;
		cmd.mwr     = MW_NONE;
		cmd.kop     = K_NONE;
		cmd.dop     = D_NONE;
		cmd.cop     = CN_NONE;
		cmd.st      = ST_DONE;
		state_d     = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid && !busy_q) begin
					cmd.capture = 1'b1;
					state_d = S_NSCAN;
				end
			end
			S_NSCAN: begin
				if (sts.i_end) begin
					state_d = S_DISPATCH;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_DISPATCH: begin
				cmd.st_en = 1'b1;
				state_d = S_FIN;
				case (sts.op)
					OP_ADD_NODE: begin
						if (sts.hit) begin
							cmd.st = ST_NOCHANGE;
						end else if (sts.full) begin
							cmd.st = ST_FULL;
						end else begin
							cmd.node_add = 1'b1;
						end
					end
					OP_REM_NODE: begin
						if (!sts.hit) begin
							cmd.st = ST_NOCHANGE;
						end else begin
							cmd.i_clr = 1'b1;
							state_d = S_RROW;
						end
					end
					OP_ADD_EDGE, OP_REM_EDGE, OP_FIND_EDGE: begin
						cmd.st = ST_NOCHANGE;
						if (sts.hit) begin
							cmd.rs_sel   = RS_NODE;
							cmd.key_sel  = KEY_TARGET;
							cmd.loc_init = 1'b1;
							state_d = S_LRD;
						end
					end
					OP_FIND_NODE, OP_NAME_POS: begin
						cmd.st = sts.hit ? ST_DONE : ST_NOCHANGE;
					end
					OP_CNT_NODES: begin
						cmd.cop = CN_TOTAL;
					end
					OP_CNT_EDGES: begin
						cmd.i_clr = 1'b1;
						state_d = S_EROW;
					end
					OP_CNT_LOOPS: begin
						cmd.i_clr = 1'b1;
						state_d = S_RROW;
					end
					OP_POS_NAME: begin
						cmd.st = sts.row_ok ? ST_DONE : ST_RANGE;
					end
					OP_MATRIX: begin
						if (!sts.rc_ok) begin
							cmd.st = ST_RANGE;
						end else begin
							cmd.psel    = PS_COL;
							cmd.key_sel = KEY_PNAME;
							state_d = S_MROW;
						end
					end
					default: begin
						cmd.st = ST_NOCHANGE;
					end
				endcase
			end
			// Per row: drop edges into a removed node, or look for a self-loop.
			S_RROW: begin
				if (sts.i_end) begin
					cmd.node_del = (sts.op == OP_REM_NODE);
					state_d = S_FIN;
				end else begin
					cmd.psel     = PS_I;
					cmd.rs_sel   = RS_PERM;
					cmd.key_sel  = (sts.op == OP_REM_NODE) ? KEY_NAME : KEY_PNAME;
					cmd.loc_init = 1'b1;
					state_d = S_LRD;
				end
			end
			S_EROW: begin
				if (sts.i_end) begin
					state_d = S_FIN;
				end else begin
					cmd.psel   = PS_I;
					cmd.rs_sel = RS_PERM;
					state_d = S_EADD;
				end
			end
			S_EADD: begin
				cmd.cop   = CN_DEG;
				cmd.i_inc = 1'b1;
				state_d = S_EROW;
			end
			S_MROW: begin
				cmd.psel     = PS_ROW;
				cmd.rs_sel   = RS_PERM;
				cmd.loc_init = 1'b1;
				state_d = S_LRD;
			end
			// Edge list search: read one entry, then compare it.
			S_LRD: begin
				if (sts.j_end) begin
					state_d = S_LDONE;
				end else begin
					cmd.mrd = MR_LOC;
					state_d = S_LCMP;
				end
			end
			S_LCMP: begin
				cmd.loc_cmp = 1'b1;
				state_d = S_LRD;
			end
			S_LDONE: begin
				state_d = S_FIN;
				case (sts.op)
					OP_ADD_EDGE: begin
						cmd.st_en = 1'b1;
						if (sts.ehit) begin
							cmd.st = ST_NOCHANGE;
						end else if (sts.row_full) begin
							cmd.st = ST_FULL;
						end else begin
							cmd.kop = K_LOAD_DEG;
							state_d = S_IRD;
						end
					end
					OP_REM_EDGE: begin
						if (sts.ehit) begin
							cmd.kop = K_LOAD_E;
							state_d = S_DRD;
						end
					end
					OP_FIND_EDGE: begin
						cmd.st_en = 1'b1;
						cmd.st = sts.ehit ? ST_DONE : ST_NOCHANGE;
					end
					OP_REM_NODE: begin
						if (sts.ehit) begin
							cmd.kop = K_LOAD_E;
							state_d = S_DRD;
						end else begin
							cmd.i_inc = 1'b1;
							state_d = S_RROW;
						end
					end
					OP_CNT_LOOPS: begin
						cmd.cop   = CN_HIT;
						cmd.i_inc = 1'b1;
						state_d = S_RROW;
					end
					OP_MATRIX: begin
						if (sts.ehit) begin
							cmd.mrd = MR_E;
							state_d = S_WCAP;
						end else begin
							cmd.st_en = 1'b1;
							cmd.st = ST_NOCHANGE;
						end
					end
					default: ;
				endcase
			end
			// Close the gap left by a removed edge: S_DRD reads the next entry and S_DWR writes it one place down.
			S_DRD: begin
				if (sts.drop_end) begin
					cmd.dop = D_DEC;
					if (sts.op == OP_REM_NODE) begin
						cmd.i_inc = 1'b1;
						state_d = S_RROW;
					end else begin
						cmd.st_en = 1'b1;
						cmd.st = ST_DONE;
						state_d = S_FIN;
					end
				end else begin
					cmd.mrd = MR_UP;
					state_d = S_DWR;
				end
			end
			S_DWR: begin
				cmd.mwr = MW_COPY;
				cmd.kop = K_INC;
				state_d = S_DRD;
			end
			// Open a gap at the sorted place, then write the new edge.
			S_IRD: begin
				if (sts.ins_end) begin
					cmd.mwr   = MW_NEW;
					cmd.dop   = D_INC;
					cmd.st_en = 1'b1;
					cmd.st    = ST_DONE;
					state_d = S_FIN;
				end else begin
					cmd.mrd = MR_DN;
					state_d = S_IWR;
				end
			end
			S_IWR: begin
				cmd.mwr = MW_COPY;
				cmd.kop = K_DEC;
				state_d = S_IRD;
			end
			S_WCAP: begin
				cmd.w_cap = 1'b1;
				cmd.st_en = 1'b1;
				cmd.st    = ST_DONE;
				state_d = S_FIN;
			end
			S_FIN: begin
				cmd.psel = PS_ROW;
				if (sts.out_free) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== src/weighted_graph_adjacency_store.sv =====
// Weighted graph store: one word in, one result word out per operation.
// Each operation first scans the N live nodes by sorted position; edge entries are searched or moved one at a time.
// Throughput: one operation at a time; a new word is taken once the result is registered.
// Reset: asynchronous arst_n empties the node table; edge storage needs no clearing.
`timescale 1ns / 1ps
module weighted_graph_adjacency_store import wgas_pkg::*; #(
	parameter int NODES = NODES_DEF,
	parameter int EDGES = EDGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [3:0]         operation,
	input  logic [7:0]         node_name,
	input  logic [7:0]         target_name,
	input  logic signed [31:0] edge_weight,
	input  logic [3:0]         row_position,
	input  logic [3:0]         column_position,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic               found,
	output logic [8:0]         count,
	output logic [3:0]         position,
	output logic [7:0]         result_name,
	output logic signed [31:0] result_weight,
	output logic               weight_valid
);

	cmd_t cmd;
	sts_t sts;

	// Sequencer for each operation.
	wgas_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Tables, edge memory and result register.
	wgas_dp #(
		.NODES (NODES),
		.EDGES (EDGES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.operation       (operation),
		.node_name       (node_name),
		.target_name     (target_name),
		.edge_weight     (edge_weight),
		.row_position    (row_position),
		.column_position (column_position),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.found           (found),
		.count           (count),
		.position        (position),
		.result_name     (result_name),
		.result_weight   (result_weight),
		.weight_valid    (weight_valid)
	);

endmodule
